/* sv/blocked_diagonal_partitioner_top_assert.svh */
// ----------------------------------------------------------------------------
// blocked diagonal partitioner assertion macros
// shared property forms for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef BLOCKED_DIAGONAL_PARTITIONER_TOP_ASSERT_SVH
`define BLOCKED_DIAGONAL_PARTITIONER_TOP_ASSERT_SVH

// same-cycle implication
`define BDP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bdp_pkg.sv */
// ----------------------------------------------------------------------------
// bdp_pkg
// sizes, codes and item types of the blocked diagonal partitioner
// ----------------------------------------------------------------------------
package bdp_pkg;

    localparam int MAX_BLOCKS        = 64;
    localparam int OFFSETS_PER_BLOCK = 16;
    localparam int INDEX_BITS        = 16;

    localparam int BLK_W   = $clog2(MAX_BLOCKS);
    localparam int SLOT_W  = $clog2(OFFSETS_PER_BLOCK);
    localparam int FILL_W  = $clog2(OFFSETS_PER_BLOCK + 1);
    localparam int SADDR_W = BLK_W + SLOT_W;
    localparam int KEY_W   = INDEX_BITS + 1;
    localparam int TALLY_W = 16;
    localparam int BW_W    = 7;
    localparam int LANE_W  = 6;
    localparam int MIN_W   = 16;
    localparam int CC_W    = 17;
    localparam int TOTAL_W = 17;
    localparam int SUM_W   = $clog2(MAX_BLOCKS * OFFSETS_PER_BLOCK * 64 + 1);
    localparam int CFG_W   = 17;
    localparam int CIDX_W  = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [BW_W-1:0]    BW_MAX    = BW_W'(64);
    localparam logic [CC_W-1:0]    CC_MAX    = CC_W'(65536);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PLACE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MIN_COUNT    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]            mode;
        logic [INDEX_BITS-1:0] row_index;
        logic [INDEX_BITS-1:0] col_index;
        logic [31:0]           entry_value;
    } t_in_item;

    typedef struct packed {
        logic                  to_fallback;
        logic [INDEX_BITS-1:0] storage_index;
        logic [15:0]           block_number;
        logic [3:0]            offset_rank;
        logic [LANE_W-1:0]     lane_number;
        logic [31:0]           value_out;
        logic [TALLY_W-1:0]    pair_count;
        logic                  table_overflow;
        logic [TOTAL_W-1:0]    storage_total;
    } t_out_item;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [SADDR_W-1:0] addr;
        logic [KEY_W-1:0]   wkey;
        logic [TALLY_W-1:0] wtally;
    } t_slot_req;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              clr;
        logic [BLK_W-1:0]  addr;
        logic [FILL_W-1:0] wdata;
    } t_fill_req;

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [SUM_W-1:0] s);
        logic [TOTAL_W-1:0] r;
        if (SUM_W > TOTAL_W && s > SUM_W'(TOTAL_MAX)) begin
            r = TOTAL_MAX;
        end else begin
            r = TOTAL_W'(s);
        end
        return r;
    endfunction

endpackage

/* sv/bdp_ifs.sv */
// ----------------------------------------------------------------------------
// bdp channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface bdp_in_if;
    logic              valid;
    logic              ready;
    bdp_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bdp_out_if;
    logic               valid;
    logic               ready;
    bdp_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/bdp_divider.sv */
// ----------------------------------------------------------------------------
// bdp_divider
// restoring divider, one quotient bit a cycle: column into block and lane
// ----------------------------------------------------------------------------
module bdp_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [bdp_pkg::INDEX_BITS-1:0]   i_dividend,
    input  logic [bdp_pkg::BW_W-1:0]         i_divisor,
    output logic                             o_done,
    output logic [bdp_pkg::INDEX_BITS-1:0]   o_quot,
    output logic [bdp_pkg::LANE_W-1:0]       o_rem
);
    localparam int CNT_W = $clog2(bdp_pkg::INDEX_BITS);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [bdp_pkg::INDEX_BITS-1:0] r_q;
    logic [bdp_pkg::LANE_W-1:0]     r_rem;
    logic [bdp_pkg::BW_W-1:0]       r_d;
    logic [bdp_pkg::BW_W-1:0]       w_sh;
    logic                           w_ge;

    assign w_sh = {r_rem, r_q[bdp_pkg::INDEX_BITS-1]};
    assign w_ge = (w_sh >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(bdp_pkg::INDEX_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[bdp_pkg::INDEX_BITS-2:0], w_ge};
            // remainder stays below the divisor, so it fits the lane width
            r_rem <= w_ge ? bdp_pkg::LANE_W'(w_sh - r_d) : bdp_pkg::LANE_W'(w_sh);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

/* sv/bdp_slot_store.sv */
// ----------------------------------------------------------------------------
// bdp_slot_store
// offset key/tally memory and per-block fill counts with valid bits
// ----------------------------------------------------------------------------
module bdp_slot_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bdp_pkg::t_slot_req            i_slot,
    output logic [bdp_pkg::KEY_W-1:0]     o_key,
    output logic [bdp_pkg::TALLY_W-1:0]   o_tally,
    input  bdp_pkg::t_fill_req            i_fill,
    output logic [bdp_pkg::FILL_W-1:0]    o_fill
);
    localparam int SLOTS = bdp_pkg::MAX_BLOCKS * bdp_pkg::OFFSETS_PER_BLOCK;

    logic [bdp_pkg::KEY_W+bdp_pkg::TALLY_W-1:0] r_slot_mem [SLOTS];
    logic [bdp_pkg::KEY_W+bdp_pkg::TALLY_W-1:0] r_slot_q;
    logic [bdp_pkg::FILL_W-1:0]                 r_fill_mem [bdp_pkg::MAX_BLOCKS];
    logic [bdp_pkg::FILL_W-1:0]                 r_fill_q;
    logic [bdp_pkg::MAX_BLOCKS-1:0]             r_fill_vld;
    logic                                       r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_slot.wr) begin
            r_slot_mem[i_slot.addr] <= {i_slot.wkey, i_slot.wtally};
        end
        if (i_slot.rd) begin
            r_slot_q <= r_slot_mem[i_slot.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fill.wr) begin
            r_fill_mem[i_fill.addr] <= i_fill.wdata;
        end
        if (i_fill.rd) begin
            r_fill_q <= r_fill_mem[i_fill.addr];
        end
    end

    // a block never written since reset or clear reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_vld <= '0;
            r_vld_q    <= 1'b0;
        end else begin
            if (i_fill.rd) begin
                r_vld_q <= r_fill_vld[i_fill.addr];
            end
            if (i_fill.clr) begin
                r_fill_vld <= '0;
            end else if (i_fill.wr) begin
                r_fill_vld[i_fill.addr] <= 1'b1;
            end
        end
    end

    assign o_key   = r_slot_q[bdp_pkg::KEY_W+bdp_pkg::TALLY_W-1:bdp_pkg::TALLY_W];
    assign o_tally = r_slot_q[bdp_pkg::TALLY_W-1:0];
    assign o_fill  = r_vld_q ? r_fill_q : '0;
endmodule

/* sv/blocked_diagonal_partitioner_top.sv */
// ----------------------------------------------------------------------------
// blocked_diagonal_partitioner_top
// coo entries to hybrid blocked diagonal layout: count, finalize, place
// ----------------------------------------------------------------------------
// One item at a time. A load or place item passes the accepting step, the
// bit-serial column divider, a fetch of the block's fill count, a scan of the
// block's offset slots through the slot memory, then a decide and an output
// step, with a base step between them when it gets a storage index. An item
// whose block lies outside the table skips the scan. The first place item
// after loading first finalizes the layout, sweeping all 64 blocks through
// the slot memory; blocks past the column count skip the scan. Clear and
// no-operation items go straight to the output step. A result waits in an
// output register, so the next item is taken while it is still held; an item
// only stalls when its own result finds that register full.
module blocked_diagonal_partitioner_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bdp_in_if.sink                        i_in,
    bdp_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [bdp_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [bdp_pkg::CFG_W-1:0]     i_cfg_data
);
`include "blocked_diagonal_partitioner_top_assert.svh"

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FIN_BLK   = 4'd1;
    localparam logic [3:0] S_FIN_FILL  = 4'd2;
    localparam logic [3:0] S_FIN_SCAN  = 4'd3;
    localparam logic [3:0] S_FIN_WRITE = 4'd4;
    localparam logic [3:0] S_DIV       = 4'd5;
    localparam logic [3:0] S_CHECK     = 4'd6;
    localparam logic [3:0] S_FILL      = 4'd7;
    localparam logic [3:0] S_SCAN      = 4'd8;
    localparam logic [3:0] S_DECIDE    = 4'd9;
    localparam logic [3:0] S_BASE      = 4'd10;
    localparam logic [3:0] S_OUT       = 4'd11;

    localparam int BLK_W   = bdp_pkg::BLK_W;
    localparam int SLOT_W  = bdp_pkg::SLOT_W;
    localparam int FILL_W  = bdp_pkg::FILL_W;
    localparam int KEY_W   = bdp_pkg::KEY_W;
    localparam int TALLY_W = bdp_pkg::TALLY_W;
    localparam int BW_W    = bdp_pkg::BW_W;
    localparam int CC_W    = bdp_pkg::CC_W;
    localparam int IB      = bdp_pkg::INDEX_BITS;
    localparam int PROD_W  = IB + BW_W;
    localparam int RANK_W  = FILL_W;
    localparam int IDX_W   = bdp_pkg::TOTAL_W + 2;

    logic [3:0]                  r_state;
    logic [BW_W-1:0]             r_cfg_w;
    logic [bdp_pkg::MIN_W-1:0]   r_cfg_min;
    logic [CC_W-1:0]             r_cfg_cc;
    logic [BW_W-1:0]             r_hw;
    logic [bdp_pkg::MIN_W-1:0]   r_hmin;
    logic [CC_W-1:0]             r_hcc;
    logic                        r_final;
    logic [bdp_pkg::TOTAL_W-1:0] r_total;

    logic [1:0]                  r_mode;
    logic [IB-1:0]               r_col;
    logic [KEY_W-1:0]            r_off;
    logic [IB-1:0]               r_blk;
    logic [bdp_pkg::LANE_W-1:0]  r_lane;
    logic [FILL_W-1:0]           r_fill;
    logic [FILL_W-1:0]           r_k;
    logic                        r_pv;
    logic [SLOT_W-1:0]           r_pk;
    logic                        r_found;
    logic [SLOT_W-1:0]           r_mslot;
    logic [TALLY_W-1:0]          r_mtally;
    logic [RANK_W-1:0]           r_rank;
    logic [FILL_W-1:0]           r_kept;
    logic [BLK_W-1:0]            r_b;
    logic [bdp_pkg::SUM_W-1:0]   r_sum;
    bdp_pkg::t_out_item          r_res;
    logic                        r_out_valid;
    bdp_pkg::t_out_item          r_out_data;

    logic [bdp_pkg::TOTAL_W-1:0] r_base_mem [bdp_pkg::MAX_BLOCKS];
    logic [bdp_pkg::TOTAL_W-1:0] r_base_q;

    logic [BW_W-1:0]             w_w_eff;
    logic [CC_W-1:0]             w_cc_eff;
    logic [BW_W-1:0]             w_w_act;
    logic [CC_W-1:0]             w_cc_act;
    logic [PROD_W-1:0]           w_prod;
    logic                        w_out_nb;
    logic                        w_big;
    logic                        w_fin_in;
    logic                        w_fin_last;
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_load_open;
    logic                        w_full;
    logic                        w_scan_done;
    logic                        w_div_start;
    logic [IB-1:0]               w_div_num;
    logic                        w_div_done;
    logic [IB-1:0]               w_div_q;
    logic [bdp_pkg::LANE_W-1:0]  w_div_r;
    logic [KEY_W-1:0]            w_key;
    logic [TALLY_W-1:0]          w_tally;
    logic [FILL_W-1:0]           w_fill;
    logic [TALLY_W-1:0]          w_inc;
    logic [bdp_pkg::SUM_W-1:0]   w_sum_nx;
    logic [IDX_W-1:0]            w_idx;
    bdp_pkg::t_slot_req          w_slot;
    bdp_pkg::t_fill_req          w_fillreq;

    assign w_w_eff  = (r_cfg_w == '0) ? BW_W'(1) :
                      (r_cfg_w > bdp_pkg::BW_MAX) ? bdp_pkg::BW_MAX : r_cfg_w;
    assign w_cc_eff = (r_cfg_cc == '0) ? CC_W'(1) :
                      (r_cfg_cc > bdp_pkg::CC_MAX) ? bdp_pkg::CC_MAX : r_cfg_cc;
    assign w_w_act  = r_final ? r_hw : w_w_eff;
    assign w_cc_act = r_final ? r_hcc : w_cc_eff;

    // block exists when its first column lies below the column count
    assign w_prod   = PROD_W'(r_blk) * PROD_W'(w_w_act);
    assign w_out_nb = (w_prod >= PROD_W'(w_cc_act));
    assign w_big    = (r_blk >= IB'(bdp_pkg::MAX_BLOCKS));
    assign w_fin_in = ((CC_W'(r_b) * CC_W'(r_hw)) < r_hcc);
    assign w_fin_last = (r_b == BLK_W'(bdp_pkg::MAX_BLOCKS - 1));

    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_load_open = (r_mode == bdp_pkg::MODE_LOAD) && !r_final;
    assign w_full      = (r_fill >= FILL_W'(bdp_pkg::OFFSETS_PER_BLOCK));
    assign w_scan_done = (r_k >= r_fill) && !r_pv;
    assign w_inc       = (r_mtally == '1) ? r_mtally : r_mtally + 1'b1;
    assign w_sum_nx    = r_sum + bdp_pkg::SUM_W'(r_kept) * bdp_pkg::SUM_W'(r_hw);
    assign w_idx       = IDX_W'(r_base_q) + IDX_W'(r_rank) * IDX_W'(w_w_act)
                         + IDX_W'(r_lane);

    assign w_div_start = (w_accept && (i_in.data.mode == bdp_pkg::MODE_LOAD ||
                          (i_in.data.mode == bdp_pkg::MODE_PLACE && r_final))) ||
                         (r_state == S_FIN_WRITE && w_fin_last);
    assign w_div_num   = (r_state == S_IDLE) ? i_in.data.col_index : r_col;

    bdp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_w_act),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    always_comb begin
        w_slot    = '0;
        w_fillreq = '0;
        case (r_state)
            S_IDLE: begin
                w_fillreq.clr = w_accept && (i_in.data.mode == bdp_pkg::MODE_CLEAR);
            end
            S_FIN_BLK: begin
                w_fillreq.rd   = w_fin_in;
                w_fillreq.addr = r_b;
            end
            S_FIN_SCAN: begin
                w_slot.rd   = (r_k < r_fill);
                w_slot.addr = {r_b, r_k[SLOT_W-1:0]};
            end
            S_CHECK: begin
                w_fillreq.rd   = 1'b1;
                w_fillreq.addr = r_blk[BLK_W-1:0];
            end
            S_SCAN: begin
                w_slot.rd   = (r_k < r_fill);
                w_slot.addr = {r_blk[BLK_W-1:0], r_k[SLOT_W-1:0]};
            end
            S_DECIDE: begin
                if (w_load_open) begin
                    if (r_found) begin
                        w_slot.wr     = 1'b1;
                        w_slot.addr   = {r_blk[BLK_W-1:0], r_mslot};
                        w_slot.wkey   = r_off;
                        w_slot.wtally = w_inc;
                    end else if (!w_full) begin
                        w_slot.wr       = 1'b1;
                        w_slot.addr     = {r_blk[BLK_W-1:0], r_fill[SLOT_W-1:0]};
                        w_slot.wkey     = r_off;
                        w_slot.wtally   = TALLY_W'(1);
                        w_fillreq.wr    = 1'b1;
                        w_fillreq.addr  = r_blk[BLK_W-1:0];
                        w_fillreq.wdata = r_fill + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    bdp_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (w_slot),
        .o_key   (w_key),
        .o_tally (w_tally),
        .i_fill  (w_fillreq),
        .o_fill  (w_fill)
    );

    // block base memory, written during finalize
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN_WRITE) begin
            r_base_mem[r_b] <= bdp_pkg::sat_total(r_sum);
        end
        r_base_q <= r_base_mem[r_blk[BLK_W-1:0]];
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_w     <= BW_W'(8);
            r_cfg_min   <= bdp_pkg::MIN_W'(1);
            r_cfg_cc    <= bdp_pkg::CC_MAX;
            r_final     <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bdp_pkg::CFG_BLOCK_WIDTH:  r_cfg_w   <= i_cfg_data[BW_W-1:0];
                    bdp_pkg::CFG_MIN_COUNT:    r_cfg_min <= i_cfg_data[bdp_pkg::MIN_W-1:0];
                    bdp_pkg::CFG_COLUMN_COUNT: r_cfg_cc  <= i_cfg_data[CC_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.data.mode)
                            bdp_pkg::MODE_CLEAR: begin
                                r_final <= 1'b0;
                                r_total <= '0;
                                r_state <= S_OUT;
                            end
                            bdp_pkg::MODE_NOP: r_state <= S_OUT;
                            bdp_pkg::MODE_PLACE: r_state <= r_final ? S_DIV : S_FIN_BLK;
                            default: r_state <= S_DIV;
                        endcase
                    end
                end
                S_FIN_BLK:  r_state <= w_fin_in ? S_FIN_FILL : S_FIN_WRITE;
                S_FIN_FILL: begin
                    r_pv    <= 1'b0;
                    r_state <= S_FIN_SCAN;
                end
                S_FIN_SCAN, S_SCAN: begin
                    r_pv <= (r_k < r_fill);
                    if (w_scan_done) begin
                        r_state <= (r_state == S_SCAN) ? S_DECIDE : S_FIN_WRITE;
                    end
                end
                S_FIN_WRITE: begin
                    if (w_fin_last) begin
                        r_total <= bdp_pkg::sat_total(w_sum_nx);
                        r_final <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_FIN_BLK;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_out_nb || w_big) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_pv    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_DECIDE: begin
                    if (!w_load_open && r_found && r_mode == bdp_pkg::MODE_PLACE &&
                        r_mtally >= r_hmin) begin
                        r_state <= S_BASE;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_BASE: r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_mode <= i_in.data.mode;
                    r_col  <= i_in.data.col_index;
                    r_off  <= {1'b0, i_in.data.col_index} - {1'b0, i_in.data.row_index};
                    r_res  <= '{value_out: i_in.data.entry_value, default: '0};
                    r_hw   <= r_final ? r_hw : w_w_eff;
                    r_hmin <= r_final ? r_hmin : r_cfg_min;
                    r_hcc  <= r_final ? r_hcc : w_cc_eff;
                    r_b    <= '0;
                    r_sum  <= '0;
                end
            end
            S_FIN_BLK: r_kept <= '0;
            S_FIN_FILL, S_FILL: begin
                r_fill  <= w_fill;
                r_k     <= '0;
                r_found <= 1'b0;
                r_rank  <= '0;
            end
            S_FIN_SCAN, S_SCAN: begin
                if (r_k < r_fill) begin
                    r_k  <= r_k + 1'b1;
                    r_pk <= r_k[SLOT_W-1:0];
                end
                if (r_pv) begin
                    if (r_state == S_FIN_SCAN) begin
                        if (w_tally >= r_hmin) begin
                            r_kept <= r_kept + 1'b1;
                        end
                    end else begin
                        if (w_key == r_off) begin
                            r_found  <= 1'b1;
                            r_mslot  <= r_pk;
                            r_mtally <= w_tally;
                        end
                        if (w_tally >= r_hmin && $signed(w_key) < $signed(r_off)) begin
                            r_rank <= r_rank + 1'b1;
                        end
                    end
                end
            end
            S_FIN_WRITE: begin
                r_sum <= w_sum_nx;
                r_b   <= r_b + 1'b1;
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_blk  <= w_div_q;
                    r_lane <= w_div_r;
                end
            end
            S_CHECK: begin
                r_res.block_number  <= r_blk;
                r_res.lane_number   <= r_lane;
                r_res.storage_total <= r_total;
                if (w_load_open) begin
                    r_res.table_overflow <= !w_out_nb && w_big;
                end else if (w_out_nb || w_big) begin
                    r_res.table_overflow <= !w_out_nb;
                    r_res.to_fallback    <= (r_mode == bdp_pkg::MODE_PLACE);
                end
            end
            S_DECIDE: begin
                if (w_load_open) begin
                    if (r_found) begin
                        r_res.pair_count <= w_inc;
                    end else if (w_full) begin
                        r_res.table_overflow <= 1'b1;
                    end else begin
                        r_res.pair_count <= TALLY_W'(1);
                    end
                end else if (!r_found) begin
                    r_res.table_overflow <= w_full;
                    r_res.to_fallback    <= (r_mode == bdp_pkg::MODE_PLACE);
                end else begin
                    r_res.pair_count <= r_mtally;
                    if (r_mode == bdp_pkg::MODE_PLACE && r_mtally < r_hmin) begin
                        r_res.to_fallback <= 1'b1;
                    end
                end
            end
            S_BASE: begin
                r_res.storage_index <= w_idx[IB-1:0];
                r_res.offset_rank   <= r_rank[3:0];
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_data <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    `BDP_ASSERT_NXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && w_out_free, r_out_valid, "result not presented")
    `BDP_ASSERT_NXT(a_fin_done, i_clk, i_rst_n, (r_state == S_FIN_WRITE) && w_fin_last, r_final && (r_state == S_DIV), "finalize did not complete")
    `BDP_ASSERT_IMP(a_div_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "divider finished outside divide state")
    `BDP_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, (r_state == S_SCAN) || (r_state == S_FIN_SCAN), r_fill <= FILL_W'(bdp_pkg::OFFSETS_PER_BLOCK), "block fill beyond capacity")
endmodule

/* test/tb_bdp_layout_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdp layout checker
// watches the item channels and the register port of the partitioner,
// predicts every result item from its own copy of the count tables and the
// finalized layout, and compares each accepted result with the oldest one due
// ----------------------------------------------------------------------------
module tb_bdp_layout_checker
    import bdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bdp_in_if                 i_in,
    bdp_out_if                i_out,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int NSLOT = MAX_BLOCKS * OFFSETS_PER_BLOCK;

    int          diag_key   [NSLOT];
    int unsigned diag_tally [NSLOT];
    bit          diag_used  [NSLOT];
    int unsigned kept_cnt   [MAX_BLOCKS];
    int unsigned blk_base   [MAX_BLOCKS];
    bit          layout_done;
    int unsigned layout_total;

    int unsigned reg_width, reg_min, reg_cols;
    int unsigned frz_width, frz_min, frz_blocks;

    t_out_item placement_due[$];

    function automatic int unsigned clamp_width(int unsigned v);
        return (v < 1) ? 1 : ((v > 64) ? 64 : v);
    endfunction

    function automatic int unsigned block_span(int unsigned cols, int unsigned w);
        int unsigned c;
        c = (cols < 1) ? 1 : ((cols > 65536) ? 65536 : cols);
        return (c + w - 1) / w;
    endfunction

    function automatic int find_diag(int unsigned blk, int off);
        for (int k = 0; k < OFFSETS_PER_BLOCK; k++) begin
            if (diag_used[blk*OFFSETS_PER_BLOCK+k] && diag_key[blk*OFFSETS_PER_BLOCK+k] == off)
                return k;
        end
        return -1;
    endfunction

    function automatic int unsigned fill_of(int unsigned blk);
        int unsigned n;
        n = 0;
        for (int k = 0; k < OFFSETS_PER_BLOCK; k++)
            if (diag_used[blk*OFFSETS_PER_BLOCK+k]) n++;
        return n;
    endfunction

    function automatic void build_layout();
        longint unsigned acc;
        int unsigned kept;
        acc = 0;
        frz_width  = clamp_width(reg_width);
        frz_min    = reg_min;
        frz_blocks = block_span(reg_cols, frz_width);
        for (int b = 0; b < MAX_BLOCKS; b++) begin
            kept = 0;
            if (b < frz_blocks) begin
                for (int k = 0; k < OFFSETS_PER_BLOCK; k++)
                    if (diag_used[b*OFFSETS_PER_BLOCK+k] &&
                        diag_tally[b*OFFSETS_PER_BLOCK+k] >= frz_min) kept++;
            end
            kept_cnt[b] = kept;
            blk_base[b] = (acc > 131071) ? 131071 : int'(acc);
            acc += longint'(kept) * frz_width;
        end
        layout_total = (acc > 131071) ? 131071 : int'(acc);
        layout_done  = 1'b1;
    endfunction

    function automatic t_out_item place_entry(t_in_item it);
        t_out_item   r;
        int          off, k;
        int unsigned w, nb, blk, lane, s, rank;
        longint unsigned pos;
        r = '0;
        r.value_out = it.entry_value;
        off = int'(it.col_index) - int'(it.row_index);
        if (it.mode == MODE_CLEAR) begin
            diag_used    = '{default: 1'b0};
            layout_done  = 1'b0;
            layout_total = 0;
            return r;
        end
        if (it.mode == MODE_NOP) return r;
        if (it.mode == MODE_PLACE && !layout_done) build_layout();
        if (layout_done) begin
            w  = frz_width;
            nb = frz_blocks;
        end else begin
            w  = clamp_width(reg_width);
            nb = block_span(reg_cols, w);
        end
        blk  = it.col_index / w;
        lane = it.col_index % w;
        r.block_number  = blk[15:0];
        r.lane_number   = lane[LANE_W-1:0];
        r.storage_total = layout_total[TOTAL_W-1:0];
        if (it.mode == MODE_LOAD && !layout_done) begin
            if (blk >= nb) return r;
            if (blk >= MAX_BLOCKS) begin
                r.table_overflow = 1'b1;
                return r;
            end
            k = find_diag(blk, off);
            if (k >= 0) begin
                s = blk*OFFSETS_PER_BLOCK + k;
                if (diag_tally[s] < 16'hFFFF) diag_tally[s]++;
                r.pair_count = diag_tally[s][15:0];
            end else if (fill_of(blk) >= OFFSETS_PER_BLOCK) begin
                r.table_overflow = 1'b1;
            end else begin
                s = blk*OFFSETS_PER_BLOCK + fill_of(blk);
                diag_used[s]  = 1'b1;
                diag_key[s]   = off;
                diag_tally[s] = 1;
                r.pair_count  = 16'd1;
            end
            return r;
        end
        if (blk >= nb || blk >= MAX_BLOCKS) begin
            if (blk < nb) r.table_overflow = 1'b1;
            if (it.mode == MODE_PLACE) r.to_fallback = 1'b1;
            return r;
        end
        k = find_diag(blk, off);
        if (k < 0) begin
            if (fill_of(blk) >= OFFSETS_PER_BLOCK) r.table_overflow = 1'b1;
            if (it.mode == MODE_PLACE) r.to_fallback = 1'b1;
            return r;
        end
        s = blk*OFFSETS_PER_BLOCK + k;
        r.pair_count = diag_tally[s][15:0];
        if (it.mode != MODE_PLACE) return r;
        if (diag_tally[s] >= frz_min) begin
            rank = 0;
            for (int j = 0; j < OFFSETS_PER_BLOCK; j++) begin
                if (diag_used[blk*OFFSETS_PER_BLOCK+j] &&
                    diag_tally[blk*OFFSETS_PER_BLOCK+j] >= frz_min &&
                    diag_key[blk*OFFSETS_PER_BLOCK+j] < off) rank++;
            end
            pos = longint'(blk_base[blk]) + longint'(rank) * w + lane;
            r.storage_index = pos[15:0];
            r.offset_rank   = rank[3:0];
        end else begin
            r.to_fallback = 1'b1;
        end
        return r;
    endfunction

    assign o_pending = placement_due.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            diag_used    = '{default: 1'b0};
            layout_done  = 1'b0;
            layout_total = 0;
            reg_width    = 8;
            reg_min      = 1;
            reg_cols     = 65536;
            frz_width    = 8;
            frz_min      = 1;
            frz_blocks   = 0;
            placement_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_WIDTH:  reg_width = i_cfg_data[BW_W-1:0];
                    CFG_MIN_COUNT:    reg_min   = i_cfg_data[MIN_W-1:0];
                    CFG_COLUMN_COUNT: reg_cols  = i_cfg_data[CC_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                want = place_entry(i_in.data);
                placement_due = {placement_due, want};
            end
            if (i_out.valid && i_out.ready) begin
                if (placement_due.size() == 0) begin
                    $display("%0t unexpected result item: expected none got %p",
                             $realtime, i_out.data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = placement_due.pop_front();
                    if (i_out.data !== want) begin
                        $display("%0t result mismatch: expected %p got %p",
                                 $realtime, want, i_out.data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/tb_blocked_diagonal_partitioner_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_blocked_diagonal_partitioner_top
// drives load, place, clear and idle items through phases of register
// settings, with bursty input and a stalling result side; the checker beside
// the block predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_blocked_diagonal_partitioner_top;
    import bdp_pkg::*;

    localparam int ITEM_GOAL   = 1550;
    localparam int CYCLE_LIMIT = 3000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_data;
    int                fail_count;
    int                pending;
    int                cycle_count;
    int                items_sent;
    int                gap_left;
    int                burst_left;
    int                stall_phase;

    bdp_in_if  in_ch ();
    bdp_out_if out_ch ();

    blocked_diagonal_partitioner_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tb_bdp_layout_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("blocked_diagonal_partitioner_top verification failed");
            $finish;
        end
    end

    // receiver stalls: stretches always ready, then random or periodic stalls
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 300) % 3)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= ((stall_phase % 7) < 3);
        endcase
    end

    task automatic send_item(logic [1:0] mode, logic [15:0] row, logic [15:0] col,
                             logic [31:0] val);
        in_ch.data  = '{mode: mode, row_index: row, col_index: col, entry_value: val};
        in_ch.valid = 1'b1;
        // ready is registered, so its level at the falling edge holds through the next rise
        while (!in_ch.ready) @(negedge i_clk);
        @(negedge i_clk);
        if (mode != MODE_NOP) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_left > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap_left) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val[CFG_W-1:0];
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    initial begin
        int unsigned bw, mc, cc, w_eff, span, n, nofs, col, off, r;
        int unsigned ent_row [64];
        int unsigned ent_col [64];
        cycle_count = 0;
        items_sent  = 0;
        burst_left  = 0;
        gap_left    = 0;
        stall_phase = 0;
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_BLOCK_WIDTH;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: width 8, 32 blocks, offsets need two entries
        write_reg(CFG_BLOCK_WIDTH, 8);
        write_reg(CFG_MIN_COUNT, 2);
        write_reg(CFG_COLUMN_COUNT, 256);
        send_item(MODE_LOAD, 16'd0, 16'd0, 32'h0);
        send_item(MODE_LOAD, 16'd1, 16'd1, 32'hFFFF_FFFF);
        send_item(MODE_LOAD, 16'hFFFF, 16'd0, 32'h1234_5678);
        send_item(MODE_LOAD, 16'd0, 16'hFFFF, 32'h8765_4321); // column past the matrix
        send_item(MODE_NOP, 16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5);
        // fill block 0 with sixteen offsets, then one more overflows
        for (int i = 1; i <= 15; i++) send_item(MODE_LOAD, 16'(i + 10), 16'd7, 32'(i));
        send_item(MODE_PLACE, 16'd0, 16'd0, 32'h5);
        send_item(MODE_PLACE, 16'hFFFF, 16'd0, 32'h6);
        send_item(MODE_PLACE, 16'd25, 16'd7, 32'h7);
        send_item(MODE_LOAD, 16'd2, 16'd2, 32'h8);            // load after finalize
        send_item(MODE_PLACE, 16'd3, 16'hFFFF, 32'h9);
        send_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_COLUMN_COUNT, 65536);
        send_item(MODE_LOAD, 16'd0, 16'hFFFF, 32'h1);          // block beyond the table
        send_item(MODE_PLACE, 16'd0, 16'hFFFF, 32'h2);
        send_item(MODE_CLEAR, 16'd0, 16'd0, 32'h3);
        drain();

        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 5))
                0: bw = 1;
                1: bw = 64;
                2: bw = 0;
                3: bw = 127;
                default: bw = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 5))
                0: mc = 0;
                1: mc = 65535;
                2: mc = 1;
                default: mc = $urandom_range(1, 4);
            endcase
            w_eff = (bw < 1) ? 1 : ((bw > 64) ? 64 : bw);
            case ($urandom_range(0, 7))
                0: cc = 0;
                1: cc = 1;
                2: cc = 65536;
                3: cc = 131071;
                default: cc = $urandom_range(1, 64 * w_eff);
            endcase
            write_reg(CFG_BLOCK_WIDTH, bw);
            write_reg(CFG_MIN_COUNT, mc);
            write_reg(CFG_COLUMN_COUNT, cc);
            span = (cc < 1) ? 1 : ((cc > 65536) ? 65536 : cc);
            if (span > 64 * w_eff) span = 64 * w_eff;
            n    = $urandom_range(4, 40);
            nofs = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                col = $urandom_range(0, span + span / 8);
                if (col > 65535) col = 65535;
                off = $urandom_range(0, nofs - 1);
                r   = col + nofs / 2 - off;
                if (r > 65535) r = col;
                ent_row[i] = r;
                ent_col[i] = col;
            end
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 19))
                    0: send_item(MODE_LOAD, 16'($urandom), 16'($urandom), $urandom);
                    1: send_item(MODE_NOP, 16'($urandom), 16'($urandom), $urandom);
                    default: ;
                endcase
                send_item(MODE_LOAD, 16'(ent_row[i]), 16'(ent_col[i]), $urandom);
            end
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 19))
                    0: send_item(MODE_PLACE, 16'($urandom), 16'($urandom), $urandom);
                    1: send_item(MODE_LOAD, 16'(ent_row[i]), 16'(ent_col[i]), $urandom);
                    default: ;
                endcase
                send_item(MODE_PLACE, 16'(ent_row[i]), 16'(ent_col[i]), $urandom);
            end
            if ($urandom_range(0, 9) < 7) send_item(MODE_CLEAR, 16'($urandom),
                                                    16'($urandom), $urandom);
            drain();
        end

        drain();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("blocked_diagonal_partitioner_top verification clean");
        end else begin
            $display("blocked_diagonal_partitioner_top verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/bdp_pkg.sv
sv/bdp_ifs.sv
sv/bdp_divider.sv
sv/bdp_slot_store.sv
sv/blocked_diagonal_partitioner_top.sv
test/tb_bdp_layout_checker.sv
test/tb_blocked_diagonal_partitioner_top.sv
